@@ hw/rtl/bawe_pkg.sv @@
`timescale 1ns / 1ps

package bawe_pkg;

  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned SUM_W    = 40;
  localparam int unsigned SOSQ_W   = 64;
  localparam int unsigned SQ_W     = 2 * SAMPLE_W;
  localparam int unsigned DIV_W    = 64;
  localparam int unsigned ROOT_W   = DIV_W / 2;
  localparam int unsigned SDONE_W  = 32;

  localparam logic [CNT_W-1:0] BLOCK_LENGTH_RST = 16'd1000;
  localparam logic [CNT_W-1:0] TOTAL_BLOCKS_RST = 16'd100;

  localparam logic CFG_BLOCK_LENGTH = 1'b0;
  localparam logic CFG_TOTAL_BLOCKS = 1'b1;

  localparam logic [SAMPLE_W-1:0] MAG_POS_MAX = 24'h7FFFFF;
  localparam logic [SAMPLE_W-1:0] MAG_NEG_MAX = 24'h800000;
  localparam logic [SAMPLE_W-1:0] ERR_MAX     = 24'hFFFFFF;

  typedef struct packed {
    logic                    clear;
    logic [CNT_W-1:0]        k;
    logic [CNT_W-1:0]        len;
    logic signed [SUM_W-1:0] sum;
  } bawe_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } bawe_q_status_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } bawe_div_req_t;

endpackage

@@ hw/rtl/bawe_front.sv @@
`timescale 1ns / 1ps

module bawe_front import bawe_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_value_i,
  input  logic                       restart_i,
  input  logic [CNT_W-1:0]           block_length_i,
  input  logic [CNT_W-1:0]           total_blocks_i,
  input  bawe_q_status_t             q_status_i,
  output logic                       push_o,
  output bawe_entry_t                entry_o
);

  logic [CNT_W-1:0]        ibc_q, ibc_d, ibc_base;
  logic signed [SUM_W-1:0] bsum_q, bsum_d, bsum_base, bsum_nx;
  logic [CNT_W-1:0]        bcount_q, bcount_d, bcount_base;
  logic                    clr_q, clr_d, clr_base;
  logic [CNT_W-1:0]        len_eff;
  logic [CNT_W:0]          ibc_inc;
  logic                    accept, running, close;

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !q_status_i.full;

  always_comb begin
    len_eff     = (block_length_i == '0) ? CNT_W'(1) : block_length_i;
    ibc_base    = restart_i ? '0 : ibc_q;
    bsum_base   = restart_i ? '0 : bsum_q;
    bcount_base = restart_i ? '0 : bcount_q;
    clr_base    = restart_i | clr_q;
    running     = bcount_base < total_blocks_i;
    bsum_nx     = bsum_base + SUM_W'(sample_value_i);
    ibc_inc     = {1'b0, ibc_base} + (CNT_W+1)'(1);
    close       = ibc_inc >= {1'b0, len_eff};

    ibc_d    = ibc_q;
    bsum_d   = bsum_q;
    bcount_d = bcount_q;
    clr_d    = clr_q;
    push_o   = 1'b0;
    if (accept) begin
      ibc_d    = ibc_base;
      bsum_d   = bsum_base;
      bcount_d = bcount_base;
      clr_d    = clr_base;
      if (running) begin
        if (close) begin
          ibc_d    = '0;
          bsum_d   = '0;
          bcount_d = bcount_base + CNT_W'(1);
          clr_d    = 1'b0;
          push_o   = 1'b1;
        end else begin
          ibc_d  = ibc_inc[CNT_W-1:0];
          bsum_d = bsum_nx;
        end
      end
    end

    entry_o.clear = clr_base;
    entry_o.k     = bcount_base + CNT_W'(1);
    entry_o.len   = len_eff;
    entry_o.sum   = bsum_nx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ibc_q    <= '0;
      bsum_q   <= '0;
      bcount_q <= '0;
      clr_q    <= 1'b0;
    end else begin
      ibc_q    <= ibc_d;
      bsum_q   <= bsum_d;
      bcount_q <= bcount_d;
      clr_q    <= clr_d;
    end
  end

endmodule

@@ hw/rtl/bawe_queue.sv @@
`timescale 1ns / 1ps

module bawe_queue import bawe_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bawe_entry_t    entry_i,
  input  logic           pop_i,
  output bawe_entry_t    head_o,
  output bawe_q_status_t status_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_QW = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_QW-1:0] CNT_FULL = CNT_QW'(DEPTH);

  bawe_entry_t       slot_q [DEPTH];
  logic [PTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CNT_QW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_LAST) ? '0 : wr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_LAST) ? '0 : rd_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_QW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_QW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= entry_i;
    end
  end

  assign head_o         = slot_q[rd_q];
  assign status_o.full  = (cnt_q == CNT_FULL);
  assign status_o.empty = (cnt_q == '0);

endmodule

@@ hw/rtl/bawe_div.sv @@
`timescale 1ns / 1ps

module bawe_div import bawe_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bawe_div_req_t    req_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quot_o
);

  localparam int unsigned STEP_W = $clog2(DIV_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_W - 1);

  logic              busy_q, done_q;
  logic [STEP_W-1:0] step_q;
  logic [DIV_W-1:0]  num_q;
  logic [CNT_W-1:0]  rem_q, den_q;
  logic [CNT_W:0]    rem_sh, rem_nx;
  logic              ge;

  always_comb begin
    rem_sh = {rem_q, num_q[DIV_W-1]};
    ge     = rem_sh >= {1'b0, den_q};
    rem_nx = ge ? rem_sh - {1'b0, den_q} : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= STEP_LAST;
      end else if (busy_q) begin
        step_q <= step_q - STEP_W'(1);
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.dividend;
      den_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[DIV_W-2:0], ge};
      rem_q <= rem_nx[CNT_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

@@ hw/rtl/bawe_root.sv @@
`timescale 1ns / 1ps

module bawe_root import bawe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_W-1:0]  rad_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam int unsigned STEP_W = $clog2(ROOT_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(ROOT_W - 1);
  localparam int unsigned REM_W = ROOT_W + 1;

  logic              busy_q, done_q;
  logic [STEP_W-1:0] step_q;
  logic [DIV_W-1:0]  x_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [REM_W+1:0]  rem_sh, trial, rem_nx;
  logic              ge;

  always_comb begin
    rem_sh = {rem_q, x_q[DIV_W-1:DIV_W-2]};
    trial  = {1'b0, root_q, 2'b01};
    ge     = rem_sh >= trial;
    rem_nx = ge ? rem_sh - trial : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_LAST;
      end else if (busy_q) begin
        step_q <= step_q - STEP_W'(1);
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      x_q    <= {x_q[DIV_W-3:0], 2'b00};
      rem_q  <= rem_nx[REM_W-1:0];
      root_q <= {root_q[ROOT_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

@@ hw/rtl/bawe_back.sv @@
`timescale 1ns / 1ps

module bawe_back import bawe_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bawe_entry_t                head_i,
  input  bawe_q_status_t             q_status_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [CNT_W-1:0]           blocks_done_o,
  output logic [SDONE_W-1:0]         samples_done_o,
  output logic signed [SAMPLE_W-1:0] progressive_mean_o,
  output logic [SAMPLE_W-1:0]        progressive_error_o
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_MEAN = 11'b000_0000_0010,
    S_SQ   = 11'b000_0000_0100,
    S_SUM  = 11'b000_0000_1000,
    S_PM   = 11'b000_0001_0000,
    S_PMW  = 11'b000_0010_0000,
    S_MSQ  = 11'b000_0100_0000,
    S_VAR  = 11'b000_1000_0000,
    S_VARW = 11'b001_0000_0000,
    S_ROOT = 11'b010_0000_0000,
    S_OUT  = 11'b100_0000_0000
  } bawe_state_e;

  bawe_state_e state_q, state_d;

  logic                       clr_q, neg_q, out_valid_q, out_valid_d;
  logic [CNT_W-1:0]           k_q, len_q;
  logic signed [SAMPLE_W-1:0] mean_q, pm_q;
  logic [SAMPLE_W-1:0]        mag_q, pm_mag_q, err_q;
  logic [SQ_W-1:0]            sq_q, pm2_q;
  logic [SDONE_W-1:0]         sdone_q;
  logic signed [SUM_W-1:0]    som_q;
  logic [SOSQ_W-1:0]          sosq_q, var_q;
  logic [SUM_W-1:0]           head_mag, som_mag;
  logic [SAMPLE_W-1:0]        mean_mag;
  logic [CNT_W-1:0]           blocks_q;
  logic [SDONE_W-1:0]         samples_q;
  logic signed [SAMPLE_W-1:0] pmean_q;
  logic [SAMPLE_W-1:0]        perr_q;

  bawe_div_req_t     div_req;
  logic              div_done, root_start, root_done, load_out;
  logic [DIV_W-1:0]  quot;
  logic [ROOT_W-1:0] root;

  bawe_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (quot)
  );

  bawe_root u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .rad_i   (quot),
    .done_o  (root_done),
    .root_o  (root)
  );

  always_comb begin
    head_mag = head_i.sum[SUM_W-1] ? SUM_W'(-head_i.sum) : SUM_W'(head_i.sum);
    som_mag  = som_q[SUM_W-1] ? SUM_W'(-som_q) : SUM_W'(som_q);
    if (neg_q) begin
      mean_mag = (quot > DIV_W'(MAG_NEG_MAX)) ? MAG_NEG_MAX : quot[SAMPLE_W-1:0];
    end else begin
      mean_mag = (quot > DIV_W'(MAG_POS_MAX)) ? MAG_POS_MAX : quot[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    state_d          = state_q;
    pop_o            = 1'b0;
    root_start       = 1'b0;
    load_out         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    unique case (state_q)
      S_IDLE: begin
        if (!q_status_i.empty) begin
          pop_o            = 1'b1;
          div_req.start    = 1'b1;
          div_req.dividend = DIV_W'(head_mag);
          div_req.divisor  = head_i.len;
          state_d          = S_MEAN;
        end
      end
      S_MEAN: begin
        if (div_done) begin
          state_d = S_SQ;
        end
      end
      S_SQ:  state_d = S_SUM;
      S_SUM: state_d = S_PM;
      S_PM: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(som_mag);
        div_req.divisor  = k_q;
        state_d          = S_PMW;
      end
      S_PMW: begin
        if (div_done) begin
          if (k_q == CNT_W'(1)) begin
            state_d = S_OUT;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = sosq_q;
            div_req.divisor  = k_q;
            state_d          = S_MSQ;
          end
        end
      end
      S_MSQ: begin
        if (div_done) begin
          state_d = S_VAR;
        end
      end
      S_VAR: begin
        div_req.start    = 1'b1;
        div_req.dividend = var_q;
        div_req.divisor  = k_q - CNT_W'(1);
        state_d          = S_VARW;
      end
      S_VARW: begin
        if (div_done) begin
          root_start = 1'b1;
          state_d    = S_ROOT;
        end
      end
      S_ROOT: begin
        if (root_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      som_q  <= '0;
      sosq_q <= '0;
    end else if (state_q == S_SUM) begin
      som_q  <= (clr_q ? '0 : som_q) + SUM_W'(mean_q);
      sosq_q <= (clr_q ? '0 : sosq_q) + SOSQ_W'(sq_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      clr_q <= head_i.clear;
      k_q   <= head_i.k;
      len_q <= head_i.len;
      neg_q <= head_i.sum[SUM_W-1];
    end
    if (state_q == S_MEAN && div_done) begin
      mag_q  <= mean_mag;
      mean_q <= neg_q ? SAMPLE_W'(-mean_mag) : mean_mag;
    end
    if (state_q == S_SQ) begin
      sq_q    <= SQ_W'(mag_q) * SQ_W'(mag_q);
      sdone_q <= SDONE_W'(k_q) * SDONE_W'(len_q);
    end
    if (state_q == S_PM) begin
      neg_q <= som_q[SUM_W-1];
    end
    if (state_q == S_PMW && div_done) begin
      pm_mag_q <= quot[SAMPLE_W-1:0];
      pm_q     <= neg_q ? SAMPLE_W'(-quot[SAMPLE_W-1:0]) : quot[SAMPLE_W-1:0];
      err_q    <= '0;
    end
    if (state_q == S_MSQ) begin
      pm2_q <= SQ_W'(pm_mag_q) * SQ_W'(pm_mag_q);
      if (div_done) begin
        var_q <= (quot > DIV_W'(pm2_q)) ? quot - DIV_W'(pm2_q) : '0;
      end
    end
    if (state_q == S_ROOT && root_done) begin
      err_q <= (root[ROOT_W-1:SAMPLE_W] != '0) ? ERR_MAX : root[SAMPLE_W-1:0];
    end
    if (load_out) begin
      blocks_q  <= k_q;
      samples_q <= sdone_q;
      pmean_q   <= pm_q;
      perr_q    <= err_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign blocks_done_o       = blocks_q;
  assign samples_done_o      = samples_q;
  assign progressive_mean_o  = pmean_q;
  assign progressive_error_o = perr_q;

endmodule

@@ hw/rtl/block_average_with_error.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake               Payload
// in        sink       in_valid_i/in_stall_o   sample_value_i, restart_i
// out       source     out_valid_o/out_stall_i blocks_done_o, samples_done_o,
//                                              progressive_mean_o, progressive_error_o
// cfg       sink       cfg_we_i                cfg_index_i, cfg_data_i
//
// Samples are taken one per cycle while in_stall_o is low; a sample that closes
// a block enters a queue of QUEUE_DEPTH closed blocks, and in_stall_o is high
// while it is full. The back end takes no new block until the last one is loaded
// for output; it uses the shared bit-serial divider (one quotient bit per cycle)
// and the root unit (one result bit per cycle); a first block skips the root and two divisions.
// Reset is asynchronous and takes effect at once; there is no clearing pass.

module block_average_with_error import bawe_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_value_i,
  input  logic                       restart_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [CNT_W-1:0]           blocks_done_o,
  output logic [SDONE_W-1:0]         samples_done_o,
  output logic signed [SAMPLE_W-1:0] progressive_mean_o,
  output logic [SAMPLE_W-1:0]        progressive_error_o,
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [CNT_W-1:0]           cfg_data_i
);

  logic [CNT_W-1:0] block_length_q, total_blocks_q;
  bawe_entry_t      q_entry, q_head;
  bawe_q_status_t   q_status;
  logic             q_push, q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_length_q <= BLOCK_LENGTH_RST;
      total_blocks_q <= TOTAL_BLOCKS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_BLOCK_LENGTH: block_length_q <= cfg_data_i;
        CFG_TOTAL_BLOCKS: total_blocks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bawe_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_value_i (sample_value_i),
    .restart_i      (restart_i),
    .block_length_i (block_length_q),
    .total_blocks_i (total_blocks_q),
    .q_status_i     (q_status),
    .push_o         (q_push),
    .entry_o        (q_entry)
  );

  bawe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .entry_i  (q_entry),
    .pop_i    (q_pop),
    .head_o   (q_head),
    .status_o (q_status)
  );

  bawe_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .head_i              (q_head),
    .q_status_i          (q_status),
    .pop_o               (q_pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .blocks_done_o       (blocks_done_o),
    .samples_done_o      (samples_done_o),
    .progressive_mean_o  (progressive_mean_o),
    .progressive_error_o (progressive_error_o)
  );

`ifndef SYNTHESIS
  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_status.full)
    else $error("closed block pushed into a full queue");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_status.empty)
    else $error("back end popped an empty queue");

  a_first_block_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && blocks_done_o == 16'd1) |-> progressive_error_o == 24'd0)
    else $error("first block reports a non-zero error");
`endif

endmodule

@@ tb/sv/tb_block_average_with_error.sv @@
`timescale 1ns / 1ps

module tb_block_average_with_error;
  import bawe_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned DRAIN_CYCLES = 400;
  localparam int unsigned HOLD_CYCLES  = 3000;

  typedef struct packed {
    logic [CNT_W-1:0]    blocks_done;
    logic [SDONE_W-1:0]  samples_done;
    logic [SAMPLE_W-1:0] mean;
    logic [SAMPLE_W-1:0] error;
  } block_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [SAMPLE_W-1:0] sample_value_i;
  logic                restart_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [CNT_W-1:0]    blocks_done_o;
  logic [SDONE_W-1:0]  samples_done_o;
  logic [SAMPLE_W-1:0] progressive_mean_o;
  logic [SAMPLE_W-1:0] progressive_error_o;
  logic                cfg_we_i;
  logic                cfg_index_i;
  logic [CNT_W-1:0]    cfg_data_i;

  block_result_t pending_results[$];
  int unsigned   mismatches;
  int unsigned   cycle_count;
  int unsigned   holdoff_left;
  int unsigned   burst_left;
  bit            gaps_on;
  bit            stalls_on;

  // running statistics of the block, mirrored
  bit [CNT_W-1:0] length_reg;
  bit [CNT_W-1:0] total_reg;
  longint         in_block_cnt;
  longint         block_sum;
  longint         blocks_closed;
  longint         mean_sum;
  bit [63:0]      mean_sq_sum;

  block_average_with_error i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .sample_value_i      (sample_value_i),
    .restart_i           (restart_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .blocks_done_o       (blocks_done_o),
    .samples_done_o      (samples_done_o),
    .progressive_mean_o  (progressive_mean_o),
    .progressive_error_o (progressive_error_o),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  function automatic bit [31:0] floor_root(input bit [63:0] x);
    bit [31:0] root;
    bit [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = {32'd0, root | (32'd1 << b)};
      if (trial * trial <= x) root = trial[31:0];
    end
    return root;
  endfunction

  function automatic void clear_statistics();
    in_block_cnt  = 0;
    block_sum     = 0;
    blocks_closed = 0;
    mean_sum      = 0;
    mean_sq_sum   = '0;
  endfunction

  function automatic void accumulate_sample(input logic [SAMPLE_W-1:0] value, input logic rs);
    longint        len;
    longint        mean;
    longint        pm;
    bit [63:0]     mag;
    bit [63:0]     msq;
    bit [63:0]     spread;
    bit [63:0]     err;
    longint        done;
    block_result_t r;
    len = (length_reg == 0) ? 1 : longint'(length_reg);
    if (rs) clear_statistics();
    if (blocks_closed >= longint'(total_reg)) return;
    block_sum += longint'($signed(value));
    in_block_cnt++;
    if (in_block_cnt < len) return;
    mean = block_sum / len;
    if (mean > longint'(MAG_POS_MAX)) mean = longint'(MAG_POS_MAX);
    if (mean < longint'($signed(MAG_NEG_MAX))) mean = longint'($signed(MAG_NEG_MAX));
    in_block_cnt = 0;
    block_sum    = 0;
    blocks_closed++;
    mean_sum += mean;
    mag = (mean < 0) ? -mean : mean;
    mean_sq_sum += mag * mag;
    pm = mean_sum / blocks_closed;
    if (blocks_closed == 1) begin
      err = '0;
    end else begin
      msq    = mean_sq_sum / blocks_closed;
      mag    = (pm < 0) ? -pm : pm;
      spread = (msq > mag * mag) ? msq - mag * mag : '0;
      err    = 64'(floor_root(spread / (blocks_closed - 1)));
      if (err > 64'(ERR_MAX)) err = 64'(ERR_MAX);
    end
    done           = blocks_closed * len;
    r.blocks_done  = blocks_closed[CNT_W-1:0];
    r.samples_done = done[SDONE_W-1:0];
    r.mean         = pm[SAMPLE_W-1:0];
    r.error        = err[SAMPLE_W-1:0];
    pending_results.push_back(r);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t: mismatch in %s: expected %0h, got %0h", $realtime, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    block_result_t want;
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, blocks_done", '0, 32'(blocks_done_o));
      end else begin
        want = pending_results.pop_front();
        if (blocks_done_o !== want.blocks_done)
          report_mismatch("blocks_done", 32'(want.blocks_done), 32'(blocks_done_o));
        if (samples_done_o !== want.samples_done)
          report_mismatch("samples_done", want.samples_done, samples_done_o);
        if (progressive_mean_o !== want.mean)
          report_mismatch("progressive_mean", 32'(want.mean), 32'(progressive_mean_o));
        if (progressive_error_o !== want.error)
          report_mismatch("progressive_error", 32'(want.error), 32'(progressive_error_o));
      end
    end
  end

  initial begin
    int unsigned run_left;
    bit          stalling;
    run_left    = 0;
    stalling    = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holdoff_left > 0) begin
        out_stall_i = 1'b1;
        holdoff_left--;
      end else if (!stalls_on) begin
        out_stall_i = 1'b0;
      end else begin
        if (run_left == 0) begin
          stalling = !stalling;
          run_left = stalling ? $urandom_range(1, 12) : $urandom_range(1, 20);
        end
        run_left--;
        out_stall_i = stalling;
      end
    end
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic rs);
    @(negedge clk_i);
    in_valid_i     = 1'b1;
    sample_value_i = value;
    restart_i      = rs;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    accumulate_sample(value, rs);
    if (gaps_on) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        @(negedge clk_i);
        in_valid_i     = 1'b0;
        sample_value_i = SAMPLE_W'($urandom);
        restart_i      = 1'($urandom_range(0, 1));
        repeat ($urandom_range(0, 9)) @(negedge clk_i);
        burst_left = $urandom_range(0, 24);
      end
    end
  endtask

  task automatic idle_input();
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic idx, input logic [CNT_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_BLOCK_LENGTH) length_reg = value;
    else total_reg = value;
  endtask

  task automatic set_config(input logic [CNT_W-1:0] len, input logic [CNT_W-1:0] total);
    idle_input();
    wait_drained();
    write_register(CFG_BLOCK_LENGTH, len);
    write_register(CFG_TOTAL_BLOCKS, total);
  endtask

  // reset length holds three samples open; lowering it closes a saturated block
  task automatic test_lowered_length_high();
    repeat (3) send_sample(MAG_POS_MAX, 1'b0);
    set_config(16'd2, 16'd100);
    send_sample(MAG_POS_MAX, 1'b0);
  endtask

  task automatic test_lowered_length_low();
    set_config(16'hFFFF, 16'd100);
    send_sample(MAG_NEG_MAX, 1'b1);
    repeat (2) send_sample(MAG_NEG_MAX, 1'b0);
    set_config(16'd1, 16'd100);
    send_sample(MAG_NEG_MAX, 1'b0);
  endtask

  task automatic test_zero_length();
    set_config(16'd0, 16'd100);
    send_sample(24'h000000, 1'b1);
    send_sample(24'hFFFFFF, 1'b0);
    send_sample(MAG_POS_MAX, 1'b0);
    send_sample(MAG_NEG_MAX, 1'b0);
    send_sample(24'h000100, 1'b0);
  endtask

  task automatic test_zero_total();
    set_config(16'd1, 16'd0);
    send_sample(24'h123456, 1'b1);
    send_sample(24'hABCDEF, 1'b0);
    send_sample(24'h010000, 1'b0);
  endtask

  task automatic test_finished_run();
    set_config(16'd1, 16'd2);
    send_sample(24'h020000, 1'b1);
    send_sample(24'hFE0000, 1'b0);
    send_sample(24'h555555, 1'b0);
    send_sample(24'h2AAAAA, 1'b0);
    send_sample(24'h030000, 1'b1);
  endtask

  task automatic test_restart_mid_block();
    set_config(16'd4, 16'd100);
    send_sample(24'h7F0000, 1'b1);
    send_sample(24'h7F0000, 1'b0);
    send_sample(24'h010000, 1'b1);
    send_sample(24'hFF0000, 1'b0);
    send_sample(24'h008000, 1'b0);
    send_sample(24'h000001, 1'b0);
  endtask

  // hold the receiver off so the closed-block queue fills and stalls the input
  task automatic test_backpressure();
    set_config(16'd1, 16'hFFFF);
    gaps_on      = 1'b0;
    stalls_on    = 1'b0;
    holdoff_left = HOLD_CYCLES;
    send_sample(SAMPLE_W'($urandom), 1'b1);
    repeat (11) send_sample(SAMPLE_W'($urandom), 1'b0);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] centre);
    case ($urandom_range(0, 9))
      0:       return MAG_POS_MAX;
      1:       return MAG_NEG_MAX;
      2, 3, 4: return centre + SAMPLE_W'($urandom_range(0, 16'hFFFF)) - 24'h008000;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic test_random_statistics(input logic [CNT_W-1:0] len,
                                        input logic [CNT_W-1:0] total,
                                        input int unsigned count, input bit idling);
    logic [SAMPLE_W-1:0] centre;
    set_config(len, total);
    gaps_on   = idling;
    stalls_on = idling;
    centre    = SAMPLE_W'($urandom);
    send_sample(pick_sample(centre), 1'b1);
    repeat (count - 1) begin
      if ($urandom_range(0, 29) == 0) begin
        centre = SAMPLE_W'($urandom);
        send_sample(pick_sample(centre), 1'b1);
      end else begin
        send_sample(pick_sample(centre), 1'b0);
      end
    end
  endtask

  initial begin
    in_valid_i     = 1'b0;
    sample_value_i = '0;
    restart_i      = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = CFG_BLOCK_LENGTH;
    cfg_data_i     = '0;
    rst_ni         = 1'b0;
    mismatches     = 0;
    cycle_count    = 0;
    holdoff_left   = 0;
    burst_left     = 0;
    gaps_on        = 1'b0;
    stalls_on      = 1'b0;
    length_reg     = BLOCK_LENGTH_RST;
    total_reg      = TOTAL_BLOCKS_RST;
    clear_statistics();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_lowered_length_high();
    test_lowered_length_low();
    test_zero_length();
    test_zero_total();
    test_finished_run();
    test_restart_mid_block();
    test_backpressure();
    test_random_statistics(16'd1, 16'hFFFF, 80, 1'b0);
    test_random_statistics(16'd3, 16'hFFFF, 80, 1'b1);
    test_random_statistics(16'd2, 16'd6, 60, 1'b1);
    test_random_statistics(16'd7, 16'hFFFF, 90, 1'b1);
    test_random_statistics(16'd16, 16'd40, 90, 1'b1);

    idle_input();
    wait_drained();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/bawe_pkg.sv
hw/rtl/bawe_front.sv
hw/rtl/bawe_queue.sv
hw/rtl/bawe_div.sv
hw/rtl/bawe_root.sv
hw/rtl/bawe_back.sv
hw/rtl/block_average_with_error.sv
tb/sv/tb_block_average_with_error.sv
